// File: rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // request actions
    localparam logic [1:0] ACT_PUT  = 2'd0;
    localparam logic [1:0] ACT_GET  = 2'd1;
    localparam logic [1:0] ACT_DEL  = 2'd2;
    localparam logic [1:0] ACT_LAZY = 2'd3;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_MISS     = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_DELETED  = 3'd5;

    // slot write kinds
    localparam logic [2:0] WR_CLEAR   = 3'd0;
    localparam logic [2:0] WR_PUT     = 3'd1;
    localparam logic [2:0] WR_LAZY    = 3'd2;
    localparam logic [2:0] WR_EMPTY_P = 3'd3;
    localparam logic [2:0] WR_EMPTY_W = 3'd4;
    localparam logic [2:0] WR_PLACE   = 3'd5;

    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd16;

    typedef struct packed {
        logic       load_req;
        logic       mod_start;
        logic       mod_sel_walk;
        logic       p_home;
        logic       p_inc;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       rd_en;
        logic       rd_sel_w;
        logic       wr_en;
        logic [2:0] wr_sel;
        logic       occ_inc;
        logic       occ_dec;
        logic       w_load;
        logic       w_inc;
        logic       n_clr;
        logic       n_inc;
        logic       clr_inc;
        logic       pend_load;
        logic [2:0] pend_status;
        logic       pend_hit;
        logic       out_load;
    } lpht_cmd_t;

    typedef struct packed {
        logic       mod_busy;
        logic       slot_occ;
        logic       key_match;
        logic       slot_valid;
        logic       probe_last;
        logic       full;
        logic       walk_last;
        logic       clr_last;
        logic       out_free;
        logic [1:0] action;
    } lpht_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/lpht_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpht_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value_in;

    modport source (output valid, action, key, value_in, input ready);
    modport sink   (input valid, action, key, value_in, output ready);
endinterface

interface lpht_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [2:0]            status;
    logic [VALUE_BITS-1:0] value_out;

    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lpht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

`default_nettype wire

// File: rtl/core/lpht_mod.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_mod #(
    parameter int KEY_BITS = 32,
    parameter int CNT_W    = 11,
    parameter int IDX_W    = 10
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [KEY_BITS-1:0] dividend,
    input  wire logic [CNT_W-1:0]    divisor,
    output logic                     busy,
    output logic [IDX_W-1:0]         remainder
);
    localparam int STEP_W = $clog2(KEY_BITS + 1);

    logic [STEP_W-1:0]   step_reg;
    logic [KEY_BITS-1:0] dvd_reg;
    logic [CNT_W-1:0]    dvs_reg;
    logic [CNT_W:0]      rem_reg;
    logic [CNT_W:0]      rem_sh;
    logic [CNT_W:0]      rem_next;

    // one quotient bit per cycle, restoring
    assign rem_sh   = {rem_reg[CNT_W-1:0], dvd_reg[KEY_BITS-1]};
    assign rem_next = (rem_sh >= {1'b0, dvs_reg}) ? rem_sh - {1'b0, dvs_reg} : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy     <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy     <= 1'b1;
            step_reg <= STEP_W'(KEY_BITS);
        end
        else if (busy)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy)
        begin
            dvd_reg <= {dvd_reg[KEY_BITS-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign remainder = rem_reg[IDX_W-1:0];
endmodule

`default_nettype wire

// File: rtl/core/lpht_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lpht_pkg::lpht_cmd_t     cmd,
    output lpht_pkg::lpht_sts_t          sts,
    input  wire logic                    cfg_wr_en,
    input  wire logic [lpht_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic [1:0]              req_action,
    input  wire logic [KEY_BITS-1:0]     req_key,
    input  wire logic [VALUE_BITS-1:0]   req_value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [2:0]                   out_status,
    output logic [VALUE_BITS-1:0]        out_value
);
    import lpht_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SZ_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int WORD_W = 2 + KEY_BITS + VALUE_BITS;

    logic [CFG_W-1:0]      table_size_reg;
    logic [CNT_W-1:0]      m_reg;
    logic [CNT_W-1:0]      m_clamp;
    logic [SZ_W-1:0]       tsz_ext;
    logic [1:0]            action_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_W-1:0]      p_reg;
    logic [IDX_W-1:0]      w_reg;
    logic [IDX_W-1:0]      clr_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      n_reg;
    logic [CNT_W-1:0]      occ_reg;
    logic [KEY_BITS-1:0]   rk_reg;
    logic [VALUE_BITS-1:0] rv_reg;
    logic                  rvalid_reg;
    logic [2:0]            pend_status_reg;
    logic [VALUE_BITS-1:0] pend_value_reg;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     rd_data;
    logic                  rd_occ;
    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [KEY_BITS-1:0]   mod_key;
    logic [CNT_W-1:0]      mod_div;
    logic                  mod_busy;
    logic [IDX_W-1:0]      home;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] m);
        logic [CNT_W:0] nxt;
        nxt = {{(CNT_W + 1 - IDX_W){1'b0}}, i} + 1'b1;
        return (nxt == {1'b0, m}) ? '0 : nxt[IDX_W-1:0];
    endfunction

    // clamp table size to 2 .. CAPACITY
    assign tsz_ext = SZ_W'(table_size_reg);
    always_comb
    begin
        if (tsz_ext < SZ_W'(2))
        begin
            m_clamp = CNT_W'(2);
        end
        else if (tsz_ext > SZ_W'(CAPACITY))
        begin
            m_clamp = CNT_W'(CAPACITY);
        end
        else
        begin
            m_clamp = tsz_ext[CNT_W-1:0];
        end
    end

    assign {rd_occ, rd_valid, rd_key, rd_value} = rd_data;

    assign mod_key = cmd.mod_sel_walk ? rd_key : req_key;
    assign mod_div = cmd.mod_sel_walk ? m_reg : m_clamp;

    lpht_mod #(
        .KEY_BITS (KEY_BITS),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (mod_key),
        .divisor   (mod_div),
        .busy      (mod_busy),
        .remainder (home)
    );

    always_comb
    begin
        wr_en   = cmd.wr_en;
        wr_addr = p_reg;
        wr_data = '0;
        case (cmd.wr_sel)
            WR_CLEAR:   wr_addr = clr_reg;
            WR_PUT:     wr_data = {1'b1, 1'b1, key_reg, value_reg};
            WR_LAZY:    wr_data = {1'b1, 1'b0, key_reg, rd_value};
            WR_EMPTY_P: wr_data = '0;
            WR_EMPTY_W: wr_addr = w_reg;
            WR_PLACE:   wr_data = {1'b1, rvalid_reg, rk_reg, rv_reg};
            default:    wr_en   = 1'b0;
        endcase
    end

    assign rd_addr = cmd.rd_sel_w ? w_reg : p_reg;

    lpht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
            p_reg          <= '0;
            w_reg          <= '0;
            clr_reg        <= '0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            occ_reg        <= '0;
            out_valid      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
            if (cmd.p_home)
            begin
                p_reg <= home;
            end
            else if (cmd.p_inc)
            begin
                p_reg <= wrap_inc(p_reg, m_reg);
            end
            if (cmd.w_load)
            begin
                w_reg <= p_reg;
            end
            else if (cmd.w_inc)
            begin
                w_reg <= wrap_inc(w_reg, m_reg);
            end
            if (cmd.clr_inc)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.n_clr)
            begin
                n_reg <= '0;
            end
            else if (cmd.n_inc)
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (cmd.occ_inc)
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            else if (cmd.occ_dec && occ_reg != '0)
            begin
                occ_reg <= occ_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            action_reg <= req_action;
            key_reg    <= req_key;
            value_reg  <= req_value;
            m_reg      <= m_clamp;
        end
        if (cmd.mod_sel_walk && cmd.mod_start)
        begin
            rk_reg     <= rd_key;
            rv_reg     <= rd_value;
            rvalid_reg <= rd_valid;
        end
        if (cmd.pend_load)
        begin
            pend_status_reg <= cmd.pend_status;
            pend_value_reg  <= cmd.pend_hit ? rd_value : '0;
        end
        if (cmd.out_load)
        begin
            out_status <= pend_status_reg;
            out_value  <= pend_value_reg;
        end
    end

    always_comb
    begin
        sts.mod_busy   = mod_busy;
        sts.slot_occ   = rd_occ;
        sts.key_match  = (rd_key == key_reg);
        sts.slot_valid = rd_valid;
        sts.probe_last = ({1'b0, cnt_reg} + 1'b1) >= {1'b0, m_reg};
        sts.full       = ({1'b0, occ_reg} + 1'b1) >= {1'b0, m_reg};
        sts.walk_last  = ({1'b0, n_reg} + 1'b1) >= {1'b0, m_reg};
        sts.clr_last   = (clr_reg == IDX_W'(CAPACITY - 1));
        sts.out_free   = !out_valid || out_ready;
        sts.action     = action_reg;
    end
endmodule

`default_nettype wire

// File: rtl/core/lpht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output lpht_pkg::lpht_cmd_t      cmd,
    input  wire lpht_pkg::lpht_sts_t sts
);
    import lpht_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_DNEXT = 4'd5;
    localparam logic [3:0] S_DRD   = 4'd6;
    localparam logic [3:0] S_DCHK  = 4'd7;
    localparam logic [3:0] S_DHASH = 4'd8;
    localparam logic [3:0] S_PRD   = 4'd9;
    localparam logic [3:0] S_PCHK  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       found;
    logic       live;

    assign in_ready = (state_reg == S_IDLE);
    assign found    = sts.slot_occ && sts.key_match;
    assign live     = found && sts.slot_valid;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_CLEAR;
                cmd.clr_inc = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req  = 1'b1;
                    cmd.mod_start = 1'b1;
                    state_next    = S_HASH;
                end
            end
            S_HASH:
            begin
                if (!sts.mod_busy)
                begin
                    cmd.p_home  = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_FRD;
                end
            end
            S_FRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (!sts.slot_occ || found || sts.probe_last)
                begin
                    cmd.pend_load   = 1'b1;
                    cmd.pend_status = ST_MISS;
                    state_next      = S_DONE;
                    case (sts.action)
                        ACT_PUT:
                        begin
                            if (found)
                            begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_sel      = WR_PUT;
                                cmd.pend_status = ST_UPDATED;
                            end
                            else if (!sts.slot_occ && !sts.full)
                            begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_sel      = WR_PUT;
                                cmd.occ_inc     = 1'b1;
                                cmd.pend_status = ST_INSERTED;
                            end
                            else
                            begin
                                cmd.pend_status = ST_FULL;
                            end
                        end
                        ACT_GET:
                        begin
                            if (live)
                            begin
                                cmd.pend_status = ST_HIT;
                                cmd.pend_hit    = 1'b1;
                            end
                        end
                        ACT_LAZY:
                        begin
                            if (live)
                            begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_sel      = WR_LAZY;
                                cmd.pend_status = ST_DELETED;
                            end
                        end
                        default:
                        begin
                            if (live)
                            begin
                                cmd.wr_en       = 1'b1;
                                cmd.wr_sel      = WR_EMPTY_P;
                                cmd.occ_dec     = 1'b1;
                                cmd.w_load      = 1'b1;
                                cmd.n_clr       = 1'b1;
                                cmd.pend_status = ST_DELETED;
                                state_next      = S_DNEXT;
                            end
                        end
                    endcase
                end
                else
                begin
                    cmd.p_inc   = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FRD;
                end
            end
            S_DNEXT:
            begin
                cmd.w_inc = 1'b1;
                cmd.n_inc = 1'b1;
                state_next = sts.walk_last ? S_DONE : S_DRD;
            end
            S_DRD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel_w = 1'b1;
                state_next   = S_DCHK;
            end
            S_DCHK:
            begin
                if (!sts.slot_occ)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.wr_en        = 1'b1;
                    cmd.wr_sel       = WR_EMPTY_W;
                    cmd.mod_start    = 1'b1;
                    cmd.mod_sel_walk = 1'b1;
                    state_next       = S_DHASH;
                end
            end
            S_DHASH:
            begin
                if (!sts.mod_busy)
                begin
                    cmd.p_home = 1'b1;
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (!sts.slot_occ)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_PLACE;
                    state_next = S_DNEXT;
                end
                else
                begin
                    cmd.p_inc  = 1'b1;
                    state_next = S_PRD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

`default_nettype wire

// File: rtl/core/linear_probing_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none

// open-addressing hash map with linear probing over one slot memory of
// CAPACITY words (occupied bit, value-valid bit, key, value). a request puts,
// gets, deletes or lazily deletes a key; every request gives exactly one
// response. the home slot is key modulo table_size (clamped to 2..CAPACITY),
// found by a bit-serial remainder unit. each probed slot then takes a memory
// read, then a check; an eager delete also walks the rest of the cluster,
// and each moved entry costs another remainder plus its own probe. after
// reset the block sweeps all CAPACITY slots of the memory clear and accepts
// no request until then; table_size writes are taken at any time but should
// only be made while the block is idle
module linear_probing_hash_table #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [lpht_pkg::CFG_W-1:0] cfg_wr_data,
    lpht_req_if.sink                        req,
    lpht_rsp_if.source                      rsp
);
    import lpht_pkg::*;

    // command and status between sequencer and datapath
    lpht_cmd_t cmd;
    lpht_sts_t sts;

    // sequencer: clear sweep, hash, probe, update, cluster re-placement
    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath: slot memory, remainder unit, probe pointers, response register
    lpht_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_action  (req.action),
        .req_key     (req.key),
        .req_value   (req.value_in),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_status  (rsp.status),
        .out_value   (rsp.value_out)
    );
endmodule

`default_nettype wire
